/* design/tcptt_pkg.sv */
`timescale 1ns / 1ps
package tcptt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 96;
    localparam int DUR_W         = 53;
    localparam int CNT_W         = 7;

    localparam logic [15:0] PURGE_INTERVAL_RST = 16'd3600;
    localparam logic [15:0] STALE_AGE_RST      = 16'd900;
    localparam logic signed [20:0] US_PER_S    = 21'sd1000000;

    typedef enum logic [0:0] {
        CFG_PURGE_INTERVAL = 1'b0,
        CFG_STALE_AGE      = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IGNORED       = 4'd0,
        ST_INSERTED      = 4'd1,
        ST_DUPLICATE     = 4'd2,
        ST_RST_REMOVED   = 4'd3,
        ST_RST_MISS      = 4'd4,
        ST_FIN_REPORTED  = 4'd5,
        ST_FIN_MISS      = 4'd6,
        ST_FULL          = 4'd7,
        ST_PURGED        = 4'd8,
        ST_PURGE_SKIPPED = 4'd9
    } t_status;

    typedef struct packed {
        logic             load;
        logic             rd;
        logic [IDX_W-1:0] idx;
        logic             apply;
        logic             emit;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_sts;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [31:0]      secs;
        logic [19:0]      usecs;
        logic [15:0]      dups;
    } t_entry;

endpackage

/* design/tcptt_ctl.sv */
`timescale 1ns / 1ps
module tcptt_ctl import tcptt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_busy,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_APPLY,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_in_valid) r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == IDX_W'(TABLE_ENTRIES - 1)) r_state <= S_DRAIN;
                end
                S_DRAIN: r_state <= S_APPLY;
                S_APPLY: r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_busy      = (r_state != S_IDLE);
        o_cmd.load  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd    = (r_state == S_SCAN);
        o_cmd.idx   = r_idx;
        o_cmd.apply = (r_state == S_APPLY);
        o_cmd.emit  = (r_state == S_EMIT) && i_sts.out_free;
    end

endmodule

/* design/tcptt_dp.sv */
`timescale 1ns / 1ps
module tcptt_dp import tcptt_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic              i_cfg_we,
    input  logic [0:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  logic              i_func,
    input  logic              i_flag_syn,
    input  logic              i_flag_ack,
    input  logic              i_flag_rst,
    input  logic              i_flag_fin,
    input  logic [31:0]       i_source_address,
    input  logic [31:0]       i_dest_address,
    input  logic [15:0]       i_source_port,
    input  logic [15:0]       i_dest_port,
    input  logic [31:0]       i_time_seconds,
    input  logic [19:0]       i_time_micros,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [3:0]        o_status,
    output logic [DUR_W-1:0]  o_duration_micros,
    output logic [15:0]       o_duplicate_count,
    output logic [CNT_W-1:0]  o_purged_count
);

    logic [15:0] r_interval, r_stale;
    logic [31:0] r_last;

    logic             r_func, r_syn, r_ack, r_rst, r_fin;
    logic [KEY_W-1:0] r_key, r_rkey;
    logic [31:0]      r_secs;
    logic [19:0]      r_usecs;
    logic             r_purge_go;

    t_entry                  r_mem [TABLE_ENTRIES];
    t_entry                  r_rd;
    logic [IDX_W-1:0]        r_rd_idx;
    logic                    r_rd_vld;
    logic [TABLE_ENTRIES-1:0] r_valid;

    logic             r_fwd_hit, r_rev_hit, r_free_hit;
    logic [IDX_W-1:0] r_fwd_idx, r_rev_idx, r_free_idx;
    logic [31:0]      r_fwd_secs;
    logic [19:0]      r_fwd_usecs;
    logic [15:0]      r_fwd_dups, r_rev_dups;
    logic [CNT_W-1:0] r_pcnt;

    t_status              r_res_status;
    logic [15:0]          r_res_dup;
    logic [CNT_W-1:0]     r_res_cnt;
    logic signed [53:0]   r_mul;
    logic signed [20:0]   r_udiff;

    logic               w_v, w_fwd, w_rev, w_stale;
    logic signed [32:0] w_age, w_since;
    logic               w_go;
    t_status            w_status;
    logic [15:0]        w_dup;
    logic               w_we, w_set, w_clr;
    logic [IDX_W-1:0]   w_widx, w_cidx;
    t_entry             w_wdata;
    logic [15:0]        w_dup_inc;

    assign o_sts.out_free = !o_out_valid || !i_out_stall;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= PURGE_INTERVAL_RST;
            r_stale    <= STALE_AGE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_PURGE_INTERVAL: r_interval <= i_cfg_data;
                CFG_STALE_AGE:      r_stale    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_since = $signed({1'b0, i_time_seconds}) - $signed({1'b0, r_last});
    assign w_go    = (|r_valid) && (w_since > $signed({17'b0, r_interval}));

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func     <= i_func;
            r_syn      <= i_flag_syn;
            r_ack      <= i_flag_ack;
            r_rst      <= i_flag_rst;
            r_fin      <= i_flag_fin;
            r_key      <= {i_source_address, i_dest_address, i_source_port, i_dest_port};
            r_rkey     <= {i_dest_address, i_source_address, i_dest_port, i_source_port};
            r_secs     <= i_time_seconds;
            r_usecs    <= i_time_micros;
            r_purge_go <= w_go;
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) r_rd <= r_mem[i_cmd.idx];
        if (w_we) r_mem[w_widx] <= w_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_rd_vld <= 1'b0;
        else          r_rd_vld <= i_cmd.rd;
        r_rd_idx <= i_cmd.idx;
    end

    assign w_v     = r_rd_vld && r_valid[r_rd_idx];
    assign w_fwd   = w_v && (r_rd.key == r_key);
    assign w_rev   = w_v && (r_rd.key == r_rkey);
    assign w_age   = $signed({1'b0, r_secs}) - $signed({1'b0, r_rd.secs});
    assign w_stale = w_v && r_func && r_purge_go && (w_age > $signed({17'b0, r_stale}));

    // scan trackers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_fwd_hit  <= 1'b0;
            r_rev_hit  <= 1'b0;
            r_free_hit <= 1'b0;
            r_pcnt     <= '0;
        end else if (r_rd_vld) begin
            if (w_fwd && !r_fwd_hit) begin
                r_fwd_hit   <= 1'b1;
                r_fwd_idx   <= r_rd_idx;
                r_fwd_secs  <= r_rd.secs;
                r_fwd_usecs <= r_rd.usecs;
                r_fwd_dups  <= r_rd.dups;
            end
            if (w_rev && !r_rev_hit) begin
                r_rev_hit  <= 1'b1;
                r_rev_idx  <= r_rd_idx;
                r_rev_dups <= r_rd.dups;
            end
            if (!r_valid[r_rd_idx] && !r_free_hit) begin
                r_free_hit <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
            if (w_stale && r_pcnt != {CNT_W{1'b1}}) r_pcnt <= r_pcnt + 1'b1;
        end
    end

    assign w_dup_inc = (r_fwd_dups == 16'hFFFF) ? r_fwd_dups : r_fwd_dups + 16'd1;

    always_comb begin
        w_status = ST_IGNORED;
        w_dup    = '0;
        w_we     = 1'b0;
        w_set    = 1'b0;
        w_clr    = 1'b0;
        w_widx   = r_free_idx;
        w_cidx   = r_fwd_idx;
        w_wdata  = '{key: r_key, secs: r_secs, usecs: r_usecs, dups: 16'd0};
        priority if (r_func) begin
            w_status = r_purge_go ? ST_PURGED : ST_PURGE_SKIPPED;
        end else if (r_syn && !r_ack) begin
            if (r_fwd_hit) begin
                w_status      = ST_DUPLICATE;
                w_dup         = w_dup_inc;
                w_we          = 1'b1;
                w_widx        = r_fwd_idx;
                w_wdata.dups  = w_dup_inc;
            end else if (r_free_hit) begin
                w_status = ST_INSERTED;
                w_we     = 1'b1;
                w_set    = 1'b1;
            end else begin
                w_status = ST_FULL;
            end
        end else if (r_rst) begin
            if (r_fwd_hit) begin
                w_status = ST_RST_REMOVED;
                w_dup    = r_fwd_dups;
                w_clr    = 1'b1;
            end else if (r_rev_hit) begin
                w_status = ST_RST_REMOVED;
                w_dup    = r_rev_dups;
                w_clr    = 1'b1;
                w_cidx   = r_rev_idx;
            end else begin
                w_status = ST_RST_MISS;
            end
        end else if (r_fin) begin
            if (r_fwd_hit) begin
                w_status = ST_FIN_REPORTED;
                w_dup    = r_fwd_dups;
                w_clr    = 1'b1;
            end else begin
                w_status = ST_FIN_MISS;
            end
        end else begin
            w_status = ST_IGNORED;
        end
        if (!i_cmd.apply) begin
            w_we  = 1'b0;
            w_set = 1'b0;
            w_clr = 1'b0;
        end
    end

    // valid bits and purge mark
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_last  <= '0;
        end else begin
            if (w_stale) r_valid[r_rd_idx] <= 1'b0;
            if (w_set)   r_valid[w_widx]   <= 1'b1;
            if (w_clr)   r_valid[w_cidx]   <= 1'b0;
            if (i_cmd.apply && r_func && r_purge_go) r_last <= r_secs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_res_status <= w_status;
            r_res_dup    <= w_dup;
            r_res_cnt    <= (r_func && r_purge_go) ? r_pcnt : '0;
            r_mul        <= ($signed({1'b0, r_secs}) - $signed({1'b0, r_fwd_secs})) * US_PER_S;
            r_udiff      <= $signed({1'b0, r_usecs}) - $signed({1'b0, r_fwd_usecs});
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            o_status          <= r_res_status;
            o_duplicate_count <= r_res_dup;
            o_purged_count    <= r_res_cnt;
            o_duration_micros <= (r_res_status == ST_FIN_REPORTED)
                ? (r_mul[DUR_W-1:0] + DUR_W'(r_udiff)) : '0;
        end
    end

endmodule

/* design/tcp_connection_time_tracker_unit.sv */
`timescale 1ns / 1ps
// TCP connection time tracker.
// Input channel: i_in_valid / o_in_stall with one packet or tick item per
// transfer. Output channel: o_out_valid / i_out_stall, one result per item.
// Config: i_cfg_we, i_cfg_index (0 purge interval, 1 stale age), i_cfg_data;
// write only while the block is idle.
// Each item walks the whole flow table through a single-port memory, one
// slot per cycle. One item is in flight at a time: a new item is accepted
// only after the previous result has been handed to the output register.
// The result sits in an output register and holds while the receiver stalls.
// The next item is still accepted and walked; it then waits, with o_in_stall
// high, until the held result is taken.
// Reset (synchronous, active low) clears all valid bits, the last purge
// second, and restores the register defaults (3600 s interval, 900 s age).
// No clearing pass is needed after reset.
module tcp_connection_time_tracker_unit import tcptt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [0:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic             i_func,
    input  logic             i_flag_syn,
    input  logic             i_flag_ack,
    input  logic             i_flag_rst,
    input  logic             i_flag_fin,
    input  logic [31:0]      i_source_address,
    input  logic [31:0]      i_dest_address,
    input  logic [15:0]      i_source_port,
    input  logic [15:0]      i_dest_port,
    input  logic [31:0]      i_time_seconds,
    input  logic [19:0]      i_time_micros,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [3:0]       o_status,
    output logic [DUR_W-1:0] o_duration_micros,
    output logic [15:0]      o_duplicate_count,
    output logic [CNT_W-1:0] o_purged_count
);

    t_cmd w_cmd;
    t_sts w_sts;

    tcptt_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_busy     (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    tcptt_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_func            (i_func),
        .i_flag_syn        (i_flag_syn),
        .i_flag_ack        (i_flag_ack),
        .i_flag_rst        (i_flag_rst),
        .i_flag_fin        (i_flag_fin),
        .i_source_address  (i_source_address),
        .i_dest_address    (i_dest_address),
        .i_source_port     (i_source_port),
        .i_dest_port       (i_dest_port),
        .i_time_seconds    (i_time_seconds),
        .i_time_micros     (i_time_micros),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_status          (o_status),
        .o_duration_micros (o_duration_micros),
        .o_duplicate_count (o_duplicate_count),
        .o_purged_count    (o_purged_count)
    );

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import tcptt_pkg::*;

    typedef struct {
        t_status                  status;
        logic signed [DUR_W-1:0]  duration;
        logic [15:0]              dups;
        logic [CNT_W-1:0]         purged;
    } flow_result_t;

    typedef struct {
        logic        func;
        logic        syn;
        logic        ack;
        logic        rst;
        logic        fin;
        logic [31:0] saddr;
        logic [31:0] daddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] secs;
        logic [19:0] usecs;
    } flow_item_t;

    class flow_scoreboard;
        logic        slot_used [TABLE_ENTRIES];
        logic [95:0] slot_key  [TABLE_ENTRIES];
        logic [31:0] slot_secs [TABLE_ENTRIES];
        logic [19:0] slot_us   [TABLE_ENTRIES];
        logic [15:0] slot_dups [TABLE_ENTRIES];
        logic [31:0] purge_mark;
        logic [15:0] interval;
        logic [15:0] stale_age;
        flow_result_t pending[$];
        int errors;
        int checked;
        int status_seen [10];

        function void clear();
            for (int i = 0; i < TABLE_ENTRIES; i++) slot_used[i] = 1'b0;
            purge_mark = '0;
            interval   = PURGE_INTERVAL_RST;
            stale_age  = STALE_AGE_RST;
        endfunction

        function int lookup(logic [95:0] k);
            for (int i = 0; i < TABLE_ENTRIES; i++)
                if (slot_used[i] && slot_key[i] == k) return i;
            return -1;
        endfunction

        function int occupancy();
            int n;
            n = 0;
            for (int i = 0; i < TABLE_ENTRIES; i++) if (slot_used[i]) n++;
            return n;
        endfunction

        function void note_item(flow_item_t it);
            flow_result_t r;
            logic [95:0] k;
            int s;
            int removed;
            longint now_us;
            longint then_us;
            r.status = ST_IGNORED;
            r.duration = '0;
            r.dups = '0;
            r.purged = '0;
            k = {it.saddr, it.daddr, it.sport, it.dport};
            if (it.func) begin
                if (occupancy() == 0 ||
                        longint'(it.secs) - longint'(purge_mark) <= longint'(interval)) begin
                    r.status = ST_PURGE_SKIPPED;
                end else begin
                    removed = 0;
                    for (int i = 0; i < TABLE_ENTRIES; i++)
                        if (slot_used[i] &&
                                longint'(it.secs) - longint'(slot_secs[i]) > longint'(stale_age)) begin
                            slot_used[i] = 1'b0;
                            removed++;
                        end
                    purge_mark = it.secs;
                    r.status = ST_PURGED;
                    r.purged = (removed > 127) ? 7'd127 : CNT_W'(removed);
                end
            end else if (it.syn && !it.ack) begin
                s = lookup(k);
                if (s >= 0) begin
                    if (slot_dups[s] != 16'hFFFF) slot_dups[s]++;
                    slot_secs[s] = it.secs;
                    slot_us[s] = it.usecs;
                    r.status = ST_DUPLICATE;
                    r.dups = slot_dups[s];
                end else begin
                    s = -1;
                    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) if (!slot_used[i]) s = i;
                    if (s < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        slot_used[s] = 1'b1;
                        slot_key[s] = k;
                        slot_secs[s] = it.secs;
                        slot_us[s] = it.usecs;
                        slot_dups[s] = '0;
                        r.status = ST_INSERTED;
                    end
                end
            end else if (it.rst) begin
                s = lookup(k);
                if (s < 0) s = lookup({it.daddr, it.saddr, it.dport, it.sport});
                if (s >= 0) begin
                    slot_used[s] = 1'b0;
                    r.status = ST_RST_REMOVED;
                    r.dups = slot_dups[s];
                end else begin
                    r.status = ST_RST_MISS;
                end
            end else if (it.fin) begin
                s = lookup(k);
                if (s >= 0) begin
                    now_us  = longint'(it.secs) * 1000000 + longint'(it.usecs);
                    then_us = longint'(slot_secs[s]) * 1000000 + longint'(slot_us[s]);
                    r.status = ST_FIN_REPORTED;
                    r.duration = DUR_W'(now_us - then_us);
                    r.dups = slot_dups[s];
                    slot_used[s] = 1'b0;
                end else begin
                    r.status = ST_FIN_MISS;
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(logic [3:0] st, logic [DUR_W-1:0] dur,
                                   logic [15:0] dups, logic [CNT_W-1:0] purged);
            flow_result_t e;
            if (pending.size() == 0) begin
                $error("result with nothing expected: status %0d", st);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (st < 10) status_seen[st]++;
            if (st !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, st);
                errors++;
            end
            if (dur !== e.duration) begin
                $error("duration_micros: expected %0d, got %0d", e.duration, $signed(dur));
                errors++;
            end
            if (dups !== e.dups) begin
                $error("duplicate_count: expected %0d, got %0d", e.dups, dups);
                errors++;
            end
            if (purged !== e.purged) begin
                $error("purged_count: expected %0d, got %0d", e.purged, purged);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [0:0]       i_cfg_index;
    logic [15:0]      i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    logic             i_func;
    logic             i_flag_syn;
    logic             i_flag_ack;
    logic             i_flag_rst;
    logic             i_flag_fin;
    logic [31:0]      i_source_address;
    logic [31:0]      i_dest_address;
    logic [15:0]      i_source_port;
    logic [15:0]      i_dest_port;
    logic [31:0]      i_time_seconds;
    logic [19:0]      i_time_micros;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [3:0]       o_status;
    logic [DUR_W-1:0] o_duration_micros;
    logic [15:0]      o_duplicate_count;
    logic [CNT_W-1:0] o_purged_count;

    tcp_connection_time_tracker_unit dut (.*);

    flow_scoreboard flows;
    int  hold_cycles;
    bit  stall_random;
    int  items_sent;

    // pool of flow endpoints so SYN/FIN/RST hit existing entries
    logic [31:0] pool_addr [8];
    logic [15:0] pool_port [8];
    logic [31:0] clock_secs;

    initial begin
        i_clk = 1'b0;
        forever begin
            #4 i_clk = 1'b1;
            #4 i_clk = 1'b0;
        end
    end

    initial begin
        #200ms;
        $display("FAIL");
        $finish;
    end

    // receiver stall pattern, with forced long hold-off when requested
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else if (stall_random) begin
            i_out_stall <= ($urandom_range(0, 9) < 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            flows.check_result(o_status, o_duration_micros, o_duplicate_count, o_purged_count);
    end

    task automatic send_item(flow_item_t it);
        i_in_valid       <= 1'b1;
        i_func           <= it.func;
        i_flag_syn       <= it.syn;
        i_flag_ack       <= it.ack;
        i_flag_rst       <= it.rst;
        i_flag_fin       <= it.fin;
        i_source_address <= it.saddr;
        i_dest_address   <= it.daddr;
        i_source_port    <= it.sport;
        i_dest_port      <= it.dport;
        i_time_seconds   <= it.secs;
        i_time_micros    <= it.usecs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        flows.note_item(it);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_sender(int n);
        i_in_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (flows.pending.size() != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CFG_PURGE_INTERVAL) flows.interval = val;
        else flows.stale_age = val;
    endtask

    function automatic flow_item_t pkt(logic syn, logic ack, logic rst, logic fin,
                                       int a, int b, logic [31:0] s, logic [19:0] u);
        flow_item_t it;
        it.func = 1'b0;
        it.syn = syn; it.ack = ack; it.rst = rst; it.fin = fin;
        it.saddr = pool_addr[a]; it.daddr = pool_addr[b];
        it.sport = pool_port[a]; it.dport = pool_port[b];
        it.secs = s; it.usecs = u;
        return it;
    endfunction

    function automatic flow_item_t tick(logic [31:0] s);
        flow_item_t it;
        it = '{default: '0};
        it.func = 1'b1;
        it.secs = s;
        it.usecs = 20'($urandom);
        it.saddr = $urandom; it.daddr = $urandom;
        return it;
    endfunction

    function automatic flow_item_t random_item();
        flow_item_t it;
        int a, b, kind;
        a = $urandom_range(0, 7);
        b = $urandom_range(0, 7);
        kind = $urandom_range(0, 99);
        clock_secs += $urandom_range(0, 40);
        if (kind < 8) begin
            it = tick(($urandom_range(0, 9) == 0) ? $urandom : clock_secs);
        end else if (kind < 12) begin
            it = pkt(1'b0, 1'b0, 1'b0, 1'b0, a, b, 32'd0, 20'd0);
            it.syn = 1'($urandom); it.ack = 1'($urandom);
            it.rst = 1'($urandom); it.fin = 1'($urandom);
            it.saddr = $urandom; it.daddr = $urandom;
            it.sport = 16'($urandom); it.dport = 16'($urandom);
            it.secs = $urandom; it.usecs = 20'($urandom);
        end else begin
            it = pkt(1'b0, 1'b0, 1'b0, 1'b0, a, b, clock_secs,
                     ($urandom_range(0, 19) == 0) ? 20'($urandom) : 20'($urandom_range(0, 999999)));
            if (kind < 50) it.syn = 1'b1;
            else if (kind < 62) it.rst = 1'b1;
            else if (kind < 90) it.fin = 1'b1;
            else it.ack = 1'b1;
            it.ack = it.ack | ($urandom_range(0, 9) == 0);
            it.fin = it.fin | ($urandom_range(0, 9) == 0);
            it.rst = it.rst | ($urandom_range(0, 15) == 0);
            if ($urandom_range(0, 15) == 0) it.secs = $urandom;
        end
        return it;
    endfunction

    task automatic random_phase(int n);
        int left;
        left = n;
        while (left > 0) begin
            int burst;
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0) begin
                send_item(random_item());
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 150));
        end
    endtask

    initial begin
        flow_item_t it;
        flows = new();
        flows.clear();
        hold_cycles = 0;
        stall_random = 1'b0;
        items_sent = 0;
        clock_secs = 32'd1000;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_PURGE_INTERVAL;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_func = 1'b0;
        i_flag_syn = 1'b0;
        i_flag_ack = 1'b0;
        i_flag_rst = 1'b0;
        i_flag_fin = 1'b0;
        i_source_address = '0;
        i_dest_address = '0;
        i_source_port = '0;
        i_dest_port = '0;
        i_time_seconds = '0;
        i_time_micros = '0;
        pool_addr[0] = '0;            pool_port[0] = '0;
        pool_addr[1] = 32'hFFFF_FFFF; pool_port[1] = 16'hFFFF;
        for (int i = 2; i < 8; i++) begin
            pool_addr[i] = $urandom;
            pool_port[i] = 16'($urandom);
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: tick on empty table, insert, duplicates, fin, rst on the reverse key
        send_item(tick(32'd5000));
        send_item(pkt(1'b1, 1'b0, 1'b0, 1'b0, 0, 1, 32'd0, 20'd0));
        send_item(pkt(1'b1, 1'b0, 1'b0, 1'b0, 0, 1, 32'd10, 20'hFFFFF));
        send_item(pkt(1'b1, 1'b0, 1'b1, 1'b1, 0, 1, 32'd20, 20'd5));
        send_item(pkt(1'b0, 1'b0, 1'b0, 1'b1, 0, 1, 32'd5, 20'd0));
        send_item(pkt(1'b0, 1'b0, 1'b0, 1'b1, 0, 1, 32'd5, 20'd0));
        send_item(pkt(1'b1, 1'b0, 1'b0, 1'b0, 1, 0, 32'hFFFF_FFFF, 20'd999999));
        send_item(pkt(1'b0, 1'b0, 1'b1, 1'b0, 0, 1, 32'd1, 20'd1));
        send_item(pkt(1'b0, 1'b0, 1'b1, 1'b0, 0, 1, 32'd1, 20'd1));
        send_item(pkt(1'b1, 1'b1, 1'b0, 1'b0, 2, 3, 32'd1, 20'd1));
        send_item(pkt(1'b0, 1'b1, 1'b0, 1'b1, 2, 3, 32'd1, 20'd1));
        send_item(pkt(1'b1, 1'b0, 1'b0, 1'b0, 2, 3, 32'hFFFF_FFFF, 20'd999999));
        send_item(pkt(1'b0, 1'b0, 1'b0, 1'b1, 2, 3, 32'd0, 20'd0));
        // fill the table until full
        for (int i = 0; i < TABLE_ENTRIES + 1; i++) begin
            it = pkt(1'b1, 1'b0, 1'b0, 1'b0, 4, 5, 32'(100 + i), 20'(i));
            it.sport = 16'(i);
            send_item(it);
        end
        send_item(tick(32'd100));
        send_item(tick(32'd8000));
        send_item(tick(32'd7000));
        drain();

        // extreme register settings: purge everything, one entry at a time
        write_reg(CFG_PURGE_INTERVAL, 16'd0);
        write_reg(CFG_STALE_AGE, 16'd0);
        for (int i = 0; i < 3; i++)
            send_item(pkt(1'b1, 1'b0, 1'b0, 1'b0, 6, 7, 32'(9000 + i), 20'd0));
        send_item(tick(32'd9001));
        send_item(tick(32'd9002));
        send_item(tick(32'hFFFF_FFFF));
        drain();

        // long receiver hold-off while the sender keeps offering
        hold_cycles <= 600;
        random_phase(12);
        drain();

        stall_random = 1'b1;
        write_reg(CFG_PURGE_INTERVAL, 16'd60);
        write_reg(CFG_STALE_AGE, 16'd120);
        random_phase(200);
        drain();

        write_reg(CFG_PURGE_INTERVAL, 16'hFFFF);
        write_reg(CFG_STALE_AGE, 16'hFFFF);
        random_phase(150);
        drain();

        stall_random = 1'b0;
        write_reg(CFG_PURGE_INTERVAL, 16'd10);
        write_reg(CFG_STALE_AGE, 16'd30);
        random_phase(120);
        stall_random = 1'b1;
        random_phase(100);
        drain();

        $display("covered %0d items, %0d results: inserted %0d, dup %0d, fin %0d, rst %0d",
                 items_sent, flows.checked, flows.status_seen[ST_INSERTED],
                 flows.status_seen[ST_DUPLICATE], flows.status_seen[ST_FIN_REPORTED],
                 flows.status_seen[ST_RST_REMOVED]);
        $display("full %0d, purged %0d, skipped %0d, ignored %0d",
                 flows.status_seen[ST_FULL], flows.status_seen[ST_PURGED],
                 flows.status_seen[ST_PURGE_SKIPPED], flows.status_seen[ST_IGNORED]);
        if (flows.errors == 0 && flows.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
